// ===== sv/positional_list_engine_top_assert.svh =====
// Assertion macros used by the positional list engine checker.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list engine: assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define PLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list engine: assertion failed");

`endif

// ===== sv/ple_pkg.sv =====
// Shared types and constants of the positional list engine.
package ple_pkg;

  // Field widths of a transaction.
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 6;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // Stream packing.
  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = OP_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = STATUS_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - LEN_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

  // Value returned on any error.
  localparam logic [VALUE_W-1:0] ERR_VALUE = '1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOOP,
    ST_WR,
    ST_PUT,
    ST_FETCH,
    ST_DONE
  } ple_state_t;

  // One finished result.
  typedef struct packed {
    logic signed [VALUE_W-1:0]  result_value;
    logic        [STATUS_W-1:0] status;
    logic        [LEN_W-1:0]    length;
  } ple_result_t;

endpackage

// ===== sv/positional_list_engine_top.sv =====
// Steps: a read checks the position, fetches the entry and returns it; error and unused-op transactions
// return straight after the check; insert and remove shift entries one at a time, a read then a write each.
// Flow: one transaction at a time; the next can be accepted in the cycle after a result
// is handed to the output register, which holds it while the output is stalled.
// Reset (rst, synchronous, active high) empties the list and drops any held output result;
// the entry memory is not cleared and needs no clearing pass.
module positional_list_engine_top #(
  parameter int CAPACITY = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [ple_pkg::IN_TDATA_W-1:0]       s_tdata,  // item_value[31:0], position[37:32]
  input  logic [ple_pkg::IN_TUSER_W-1:0]       s_tuser,  // op[1:0]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ple_pkg::OUT_TDATA_W-1:0]      m_tdata,  // result_value[31:0], length[38:32]
  output logic [ple_pkg::OUT_TUSER_W-1:0]      m_tuser   // status[1:0]
);
  import ple_pkg::*;

  logic        res_valid, res_ready;
  ple_result_t res, out_r;
  logic        out_valid;

  // Sequencer and store.
  ple_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser[OP_W-1:0]),
    .in_value (s_tdata[VALUE_W-1:0]),
    .in_pos   (s_tdata[VALUE_W +: POS_W]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Output register: take a result when empty or being drained.
  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_r.length, out_r.result_value};
  assign m_tuser  = out_r.status;

endmodule

// ===== sv/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ple_ctrl.sv =====
// Sequencer and entry store: decodes one operation and shifts entries one at a time.
module ple_ctrl #(
  parameter int CAPACITY = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [ple_pkg::OP_W-1:0]     in_op,
  input  logic signed [ple_pkg::VALUE_W-1:0]  in_value,
  input  logic        [ple_pkg::POS_W-1:0]    in_pos,
  output logic                                res_valid,
  input  logic                                res_ready,
  output ple_pkg::ple_result_t                res
);
  import ple_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  ple_state_t state, state_next;

  logic [CNT_W-1:0]          cnt, cnt_next;
  logic [CNT_W-1:0]          idx, idx_next;
  logic [CNT_W-1:0]          pos_idx, pos_idx_next;
  logic [CNT_W-1:0]          step;
  logic [OP_W-1:0]           op_r;
  logic signed [VALUE_W-1:0] val_r;
  logic [POS_W-1:0]          pos_r;
  logic signed [VALUE_W-1:0] res_val, res_next;
  logic [STATUS_W-1:0]       stat, stat_next;

  logic                      full, empty, past, up, accept;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]        ram_wdata, ram_rdata;

  // Entry store.
  ple_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Condition flags and the shared index stepper.
  assign full   = (cnt == CNT_W'(CAPACITY));
  assign empty  = (cnt == '0);
  assign past   = (CMP_W'(pos_r) >= CMP_W'(cnt));
  assign up     = (op_r == OP_INSERT);
  assign step   = up ? (idx - CNT_W'(1)) : (idx + CNT_W'(1));
  assign accept = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        unique case (op_r)
          OP_INSERT: state_next = full ? ST_DONE : ST_LOOP;
          OP_REMOVE,
          OP_READ:   state_next = (empty || past) ? ST_DONE : ST_FETCH;
          default:   state_next = ST_DONE;
        endcase
      end
      ST_LOOP: begin
        if (up) begin
          state_next = (idx == pos_idx) ? ST_PUT : ST_WR;
        end else begin
          state_next = (step < cnt) ? ST_WR : ST_DONE;
        end
      end
      ST_WR:    state_next = ST_LOOP;
      ST_PUT:   state_next = ST_DONE;
      ST_FETCH: state_next = (op_r == OP_REMOVE) ? ST_LOOP : ST_DONE;
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Datapath and memory controls per state.
  always_comb begin
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = idx[AW-1:0];
    ram_wdata    = ram_rdata;
    ram_raddr    = step[AW-1:0];
    cnt_next     = cnt;
    idx_next     = idx;
    pos_idx_next = pos_idx;
    res_next     = res_val;
    stat_next    = stat;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CHECK: begin
        // Issue the read of the target and classify the operation.
        ram_raddr    = AW'(pos_r);
        idx_next     = cnt;
        pos_idx_next = past ? cnt : CNT_W'(pos_r);
        res_next     = '0;
        stat_next    = STAT_OK;
        unique case (op_r)
          OP_INSERT: begin
            if (full) begin
              res_next  = ERR_VALUE;
              stat_next = STAT_FULL;
            end
          end
          OP_REMOVE,
          OP_READ: begin
            if (empty) begin
              res_next  = ERR_VALUE;
              stat_next = STAT_EMPTY;
            end else if (past) begin
              res_next  = ERR_VALUE;
              stat_next = STAT_BADPOS;
            end
          end
          default: begin
            res_next  = '0;
            stat_next = STAT_OK;
          end
        endcase
      end
      ST_LOOP: begin
        // Read the neighbor; on the last step of a remove drop the count.
        if (!up && !(step < cnt)) cnt_next = cnt - CNT_W'(1);
      end
      ST_WR: begin
        // Move the neighbor into this slot and advance.
        ram_we   = 1'b1;
        idx_next = step;
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_idx[AW-1:0];
        ram_wdata = val_r;
        cnt_next  = cnt + CNT_W'(1);
      end
      ST_FETCH: begin
        res_next = ram_rdata;
        idx_next = CNT_W'(pos_r);
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_op;
      val_r <= in_value;
      pos_r <= in_pos;
    end
    idx     <= idx_next;
    pos_idx <= pos_idx_next;
    res_val <= res_next;
    stat    <= stat_next;
  end

  assign res.result_value = res_val;
  assign res.status       = stat;
  assign res.length       = LEN_W'(cnt);

endmodule

// ===== sv/ple_checker.sv =====
// Port-level checker for the positional list engine, bound to the top level.
`include "positional_list_engine_top_assert.svh"

module ple_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [ple_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input logic [ple_pkg::OUT_TUSER_W-1:0]     m_tuser
);
  import ple_pkg::*;

  // Hold a stalled result.
  `PLE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Any error status carries the all-ones value.
  `PLE_ASSERT_NOW(a_err_value, m_tvalid && (m_tuser != STAT_OK), m_tdata[VALUE_W-1:0] == ERR_VALUE)

  // An empty-list error reports zero length.
  `PLE_ASSERT_NOW(a_empty_len, m_tvalid && (m_tuser == STAT_EMPTY), m_tdata[VALUE_W +: LEN_W] == '0)

  // One transaction at a time: busy right after an accept.
  `PLE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);
